// ===== src/rdc_pkg.sv =====
// package: types, codes and constants for the ring dma channel controller
package rdc_pkg;

   localparam int NumChannels = 8;
   localparam int ChanBits = (NumChannels > 1) ? $clog2(NumChannels) : 1;

   typedef enum logic [2:0] {
      REQ_CONFIGURE = 3'd0,
      REQ_START     = 3'd1,
      REQ_STOP      = 3'd2,
      REQ_SUSPEND   = 3'd3,
      REQ_RESUME    = 3'd4,
      REQ_RELOAD    = 3'd5,
      REQ_STATUS    = 3'd6,
      REQ_UNKNOWN   = 3'd7
   } req_code_type;

   localparam logic [1:0] CH_IDLE   = 2'd0;
   localparam logic [1:0] CH_CONF   = 2'd1;
   localparam logic [1:0] CH_ACTIVE = 2'd2;
   localparam logic [1:0] CH_PAUSED = 2'd3;

   localparam logic [1:0] RES_OK      = 2'd0;
   localparam logic [1:0] RES_INVALID = 2'd1;
   localparam logic [1:0] RES_NOTSUP  = 2'd2;

   localparam logic [1:0] EN_NONE    = 2'd0;
   localparam logic [1:0] EN_ENABLE  = 2'd1;
   localparam logic [1:0] EN_DISABLE = 2'd2;

   localparam logic [3:0] SampleS16 = 4'd2;
   localparam logic [3:0] SampleS32 = 4'd4;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [7:0]  chan_id;
      logic [1:0]  transfer_dir;
      logic        chan_is_playback;
      logic        cyclic;
      logic [23:0] blk_bytes;
      logic [7:0]  blk_cnt;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [3:0]  sample_bytes;
      logic [31:0] advance_bytes;
      logic [31:0] hw_position;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  enable_cmd;
      logic [31:0] rd_pos;
      logic [31:0] wr_pos;
      logic        busy_res;
      logic [31:0] pend_bytes;
      logic [31:0] free_space;
      logic        frame_format;
   } rsp_type;

   // one channel's context as held in memory
   typedef struct packed {
      logic [1:0]  state;
      logic        playback;
      logic [31:0] base;
      logic [31:0] size;
      logic [31:0] rptr;
      logic [31:0] wptr;
   } ctx_type;

   typedef struct packed {
      logic        start;
      logic [32:0] dividend;
      logic [31:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] remainder;
   } div_rsp_type;

endpackage

// ===== src/rdc_ctx_mem.sv =====
// context memory: one entry per channel, registered read
module rdc_ctx_mem
   import rdc_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ChanBits-1:0] wr_addr,
   input  ctx_type             wr_data,
   input  logic [ChanBits-1:0] rd_addr,
   output ctx_type             rd_data
);
   ctx_type mem [NumChannels];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== src/rdc_mod_unit.sv =====
// iterative remainder unit: 33-bit dividend by 32-bit divisor, one bit a cycle
module rdc_mod_unit
   import rdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_rsp_type rsp
);
   logic [32:0] rem_ff, rem_in;
   logic [32:0] dvd_ff, dvd_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [33:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dvd_ff[32]} - {2'b00, dvs_ff};
      if (cmd.start) begin
         rem_in = '0;
         dvd_in = cmd.dividend;
         dvs_in = cmd.divisor;
         cnt_in = 6'd33;
         run_in = 1'b1;
      end else if (run_ff) begin
         // shift-subtract, remainder stays below divisor
         if (!trial[33]) begin
            rem_in = trial[32:0];
         end else begin
            rem_in = {rem_ff[31:0], dvd_ff[32]};
         end
         dvd_in = {dvd_ff[31:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff[31:0];

   a_done_one: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("remainder done held two cycles");
   a_run_count: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> cnt_ff != 6'd0) else $error("remainder unit ran out of count");
   a_rem_small: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < {1'b0, dvs_ff}) else $error("remainder not reduced");
endmodule

// ===== src/rdc_seq.sv =====
// request sequencer: context read, checks, remainder steps, write back, result
module rdc_seq
   import rdc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  req_type             req,
   output logic                busy,
   output logic                done,
   output rsp_type             rsp,
   output logic [ChanBits-1:0] rd_addr,
   input  ctx_type             rd_data,
   output logic                wr_en,
   output logic [ChanBits-1:0] wr_addr,
   output ctx_type             wr_data,
   output div_cmd_type         div_cmd,
   input  div_rsp_type         div_rsp
);
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_READ  = 7'b0000010,
      S_EXEC  = 7'b0000100,
      S_MOD1  = 7'b0001000,
      S_MOD2  = 7'b0010000,
      S_MOD3  = 7'b0100000,
      S_FIN   = 7'b1000000
   } state_type;

   state_type   st_ff, st_in;
   req_type     req_ff, req_in;
   ctx_type     ctx_ff, ctx_in;
   rsp_type     rsp_ff, rsp_in;
   logic        done_ff, done_in;
   logic [31:0] r_ff, r_in;
   logic [31:0] w_ff, w_in;

   logic        in_range;
   logic [47:0] prod;
   logic [31:0] rem;
   logic [32:0] pend_sum;

   assign in_range = ({1'b0, req_ff.chan_id} < 9'(NumChannels));
   assign prod     = 48'(req_ff.blk_bytes) * 48'(req_ff.blk_cnt);
   assign rem      = div_rsp.remainder;
   assign pend_sum = {1'b0, w_ff} + {1'b0, ctx_ff.size} - {1'b0, r_ff};

   always_comb begin
      st_in   = st_ff;
      req_in  = req_ff;
      ctx_in  = ctx_ff;
      rsp_in  = rsp_ff;
      done_in = 1'b0;
      r_in    = r_ff;
      w_in    = w_ff;
      wr_en   = 1'b0;
      div_cmd = '{start: 1'b0, dividend: '0, divisor: ctx_ff.size};
      unique case (st_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req;
               st_in  = S_READ;
            end
         end
         S_READ: begin
            st_in = S_EXEC;
         end
         S_EXEC: begin
            ctx_in = rd_data;
            rsp_in = '0;
            rsp_in.status = RES_INVALID;
            st_in = S_FIN;
            if (in_range) begin
               unique case (req_code_type'(req_ff.req_type))
                  REQ_CONFIGURE: begin
                     if (!req_ff.cyclic) begin
                        rsp_in.status = RES_NOTSUP;
                     end else if (req_ff.blk_cnt == 8'd0 || req_ff.blk_bytes == 24'd0
                                  || req_ff.transfer_dir[1]
                                  || (req_ff.transfer_dir[0] == req_ff.chan_is_playback)) begin
                        rsp_in.status = RES_INVALID;
                     end else begin
                        ctx_in.base = req_ff.transfer_dir[0] ? req_ff.dst_addr
                                                             : req_ff.src_addr;
                        ctx_in.size     = prod[31:0];
                        ctx_in.playback = req_ff.chan_is_playback;
                        ctx_in.rptr     = '0;
                        ctx_in.wptr     = '0;
                        wr_en = 1'b1;
                        if (req_ff.sample_bytes == SampleS16) begin
                           rsp_in.status = RES_OK;
                           ctx_in.state  = CH_CONF;
                        end else if (req_ff.sample_bytes == SampleS32) begin
                           rsp_in.status       = RES_OK;
                           rsp_in.frame_format = 1'b1;
                           ctx_in.state        = CH_CONF;
                        end else begin
                           rsp_in.status = RES_NOTSUP;
                        end
                     end
                  end
                  REQ_START: begin
                     if (rd_data.state == CH_CONF || rd_data.state == CH_PAUSED) begin
                        ctx_in.state = CH_ACTIVE;
                        rsp_in.status = RES_OK;
                        rsp_in.enable_cmd = EN_ENABLE;
                        wr_en = 1'b1;
                     end
                  end
                  REQ_STOP: begin
                     if (rd_data.state == CH_CONF) begin
                        rsp_in.status = RES_OK;
                     end else if (rd_data.state != CH_IDLE) begin
                        ctx_in.state = CH_CONF;
                        rsp_in.status = RES_OK;
                        rsp_in.enable_cmd = EN_DISABLE;
                        wr_en = 1'b1;
                     end
                  end
                  REQ_SUSPEND: begin
                     if (rd_data.state == CH_ACTIVE) begin
                        ctx_in.state = CH_PAUSED;
                        rsp_in.status = RES_OK;
                        rsp_in.enable_cmd = EN_DISABLE;
                        wr_en = 1'b1;
                     end
                  end
                  REQ_RESUME: begin
                     if (rd_data.state == CH_PAUSED) begin
                        ctx_in.state = CH_ACTIVE;
                        rsp_in.status = RES_OK;
                        rsp_in.enable_cmd = EN_ENABLE;
                        wr_en = 1'b1;
                     end
                  end
                  REQ_RELOAD: begin
                     if (rd_data.size != 32'd0) begin
                        div_cmd.start    = 1'b1;
                        div_cmd.divisor  = rd_data.size;
                        div_cmd.dividend = rd_data.playback
                           ? {1'b0, rd_data.wptr} + {1'b0, req_ff.advance_bytes}
                           : {1'b0, rd_data.rptr} + {1'b0, req_ff.advance_bytes};
                        st_in = S_MOD1;
                     end
                  end
                  REQ_STATUS: begin
                     if (req_ff.hw_position != 32'd0 && rd_data.size != 32'd0) begin
                        div_cmd.start    = 1'b1;
                        div_cmd.divisor  = rd_data.size;
                        div_cmd.dividend = {1'b0, req_ff.hw_position - rd_data.base};
                        st_in = S_MOD1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MOD1: begin
            if (div_rsp.done) begin
               if (req_code_type'(req_ff.req_type) == REQ_RELOAD) begin
                  if (ctx_ff.playback) ctx_in.wptr = rem;
                  else ctx_in.rptr = rem;
                  rsp_in.status = RES_OK;
                  wr_en = 1'b1;
                  st_in = S_FIN;
               end else begin
                  // folded hardware position updates the hardware-owned pointer
                  if (ctx_ff.playback) ctx_in.rptr = rem;
                  else ctx_in.wptr = rem;
                  wr_en = 1'b1;
                  div_cmd.start    = 1'b1;
                  div_cmd.dividend = {1'b0, ctx_ff.playback ? ctx_ff.wptr : ctx_ff.rptr};
                  st_in = S_MOD2;
               end
            end
         end
         S_MOD2: begin
            if (div_rsp.done) begin
               if (ctx_ff.playback) begin
                  r_in = ctx_ff.rptr;
                  w_in = rem;
               end else begin
                  r_in = rem;
                  w_in = ctx_ff.wptr;
               end
               st_in = S_MOD3;
            end
         end
         S_MOD3: begin
            if (pend_sum >= {1'b0, ctx_ff.size}) begin
               rsp_in.pend_bytes = 32'(pend_sum - {1'b0, ctx_ff.size});
            end else begin
               rsp_in.pend_bytes = pend_sum[31:0];
            end
            rsp_in.free_space   = ctx_ff.size - rsp_in.pend_bytes;
            rsp_in.rd_pos       = ctx_ff.rptr + ctx_ff.base;
            rsp_in.wr_pos       = ctx_ff.wptr + ctx_ff.base;
            rsp_in.busy_res     = (ctx_ff.state == CH_ACTIVE);
            rsp_in.status       = RES_OK;
            st_in = S_FIN;
         end
         S_FIN: begin
            done_in = 1'b1;
            st_in   = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      req_ff <= req_in;
      ctx_ff <= ctx_in;
      rsp_ff <= rsp_in;
      r_ff   <= r_in;
      w_ff   <= w_in;
   end

   assign busy    = (st_ff != S_IDLE);
   assign done    = done_ff;
   assign rsp     = rsp_ff;
   assign rd_addr = req_ff.chan_id[ChanBits-1:0];
   assign wr_addr = req_ff.chan_id[ChanBits-1:0];
   assign wr_data = ctx_in;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> st_ff == S_IDLE) else $error("result strobe outside idle");
   a_no_wr_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (st_ff == S_EXEC || st_ff == S_MOD1)) else $error("stray write back");
   a_fin_done: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_FIN |=> done_ff) else $error("finish without result");
endmodule

// ===== src/ring_dma_channel_controller.sv =====
// top level: ring dma channel controller with context memory and remainder unit
//  channel   | ports                          | handshake
//  request   | start, busy, req_item          | taken when start && !busy
//  result    | rsp_valid, rsp_item            | one-cycle strobe, no stall
//  a reload uses one remainder and a status request two (33-step remainders)
//  the shared bit-serial remainder unit sets the long paths
//  context memory is read in the cycle after acceptance and written back before the result
//  synchronous reset clears only control state; memory entries are zeroed by a
//  clearing pass over every entry after reset, with busy high
module ring_dma_channel_controller
   import rdc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_item,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_item
);
   logic [ChanBits-1:0] rd_addr, wr_addr_s, wr_addr;
   logic                wr_en_s, wr_en;
   ctx_type             rd_data, wr_data_s, wr_data;
   div_cmd_type         div_cmd;
   div_rsp_type         div_rsp;
   logic                seq_busy;
   logic [ChanBits:0]   clr_ff, clr_in;
   logic                clearing;

   assign clearing    = (clr_ff != (ChanBits+1)'(NumChannels));

   always_comb begin
      clr_in = clr_ff;
      if (clearing) clr_in = clr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else clr_ff <= clr_in;
   end

   assign wr_en   = clearing | wr_en_s;
   assign wr_addr = clearing ? clr_ff[ChanBits-1:0] : wr_addr_s;
   assign wr_data = clearing ? ctx_type'('0) : wr_data_s;
   assign busy    = seq_busy | clearing;

   rdc_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start && !clearing),
      .req     (req_item),
      .busy    (seq_busy),
      .done    (rsp_valid),
      .rsp     (rsp_item),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en_s),
      .wr_addr (wr_addr_s),
      .wr_data (wr_data_s),
      .div_cmd (div_cmd),
      .div_rsp (div_rsp)
   );

   rdc_ctx_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rdc_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );
endmodule

// ===== tb/ring_dma_channel_controller_tb.sv =====
// testbench for the ring dma channel controller: directed and random requests against a predictor
`timescale 1ns / 100ps

module ring_dma_channel_controller_tb;
   import rdc_pkg::*;

   class chan_scoreboard;
      logic [1:0]  st_q   [NumChannels];
      logic        play_q [NumChannels];
      logic [31:0] base_q [NumChannels];
      logic [31:0] size_q [NumChannels];
      logic [31:0] rptr_q [NumChannels];
      logic [31:0] wptr_q [NumChannels];
      rsp_type     pending_rsp[$];
      int          errors;
      int          checked;

      function new();
         for (int i = 0; i < NumChannels; i++) begin
            st_q[i] = CH_IDLE; play_q[i] = 0; base_q[i] = 0;
            size_q[i] = 0; rptr_q[i] = 0; wptr_q[i] = 0;
         end
         errors = 0;
         checked = 0;
      endfunction

      function logic [1:0] configure(int c, req_type r, output logic fmt);
         fmt = 0;
         if (!r.cyclic) return RES_NOTSUP;
         if (r.blk_cnt == 0 || r.blk_bytes == 0) return RES_INVALID;
         if (r.transfer_dir > 1) return RES_INVALID;
         if (r.transfer_dir == 0 && !r.chan_is_playback) return RES_INVALID;
         if (r.transfer_dir == 1 && r.chan_is_playback) return RES_INVALID;
         base_q[c] = (r.transfer_dir == 0) ? r.src_addr : r.dst_addr;
         size_q[c] = r.blk_bytes * r.blk_cnt;
         play_q[c] = r.chan_is_playback;
         rptr_q[c] = 0;
         wptr_q[c] = 0;
         if (r.sample_bytes == SampleS16) fmt = 0;
         else if (r.sample_bytes == SampleS32) fmt = 1;
         else return RES_NOTSUP;
         st_q[c] = CH_CONF;
         return RES_OK;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int c;
         logic [1:0] s;
         logic [32:0] size, pos, rr, ww;
         logic f;
         e = '0;
         e.status = RES_INVALID;
         if (r.chan_id < NumChannels) begin
            c = r.chan_id;
            s = st_q[c];
            size = {1'b0, size_q[c]};
            case (req_code_type'(r.req_type))
               REQ_CONFIGURE: begin
                  e.status = configure(c, r, f);
                  e.frame_format = (e.status == RES_OK) ? f : 1'b0;
               end
               REQ_START: if (s == CH_CONF || s == CH_PAUSED) begin
                  st_q[c] = CH_ACTIVE; e.status = RES_OK; e.enable_cmd = EN_ENABLE;
               end
               REQ_STOP: begin
                  if (s == CH_CONF) e.status = RES_OK;
                  else if (s == CH_ACTIVE || s == CH_PAUSED) begin
                     st_q[c] = CH_CONF; e.status = RES_OK; e.enable_cmd = EN_DISABLE;
                  end
               end
               REQ_SUSPEND: if (s == CH_ACTIVE) begin
                  st_q[c] = CH_PAUSED; e.status = RES_OK; e.enable_cmd = EN_DISABLE;
               end
               REQ_RESUME: if (s == CH_PAUSED) begin
                  st_q[c] = CH_ACTIVE; e.status = RES_OK; e.enable_cmd = EN_ENABLE;
               end
               REQ_RELOAD: if (size != 0) begin
                  if (play_q[c]) wptr_q[c] = 32'(({1'b0, wptr_q[c]} + r.advance_bytes) % size);
                  else rptr_q[c] = 32'(({1'b0, rptr_q[c]} + r.advance_bytes) % size);
                  e.status = RES_OK;
               end
               REQ_STATUS: if (r.hw_position != 0 && size != 0) begin
                  pos = {1'b0, 32'(r.hw_position - base_q[c])};
                  if (pos >= size) pos = pos % size;
                  if (play_q[c]) rptr_q[c] = pos[31:0];
                  else wptr_q[c] = pos[31:0];
                  rr = rptr_q[c] % size;
                  ww = wptr_q[c] % size;
                  e.rd_pos = rptr_q[c] + base_q[c];
                  e.wr_pos = wptr_q[c] + base_q[c];
                  e.busy_res = (st_q[c] == CH_ACTIVE);
                  e.pend_bytes = 32'((ww + size - rr) % size);
                  e.free_space = size_q[c] - e.pend_bytes;
                  e.status = RES_OK;
               end
               default: ;
            endcase
         end
         pending_rsp.push_back(e);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         if (errors <= 40)
            $display("mismatch %0d: %s got %h expected %h", checked, what, got, want);
      endtask

      task check_result(rsp_type g);
         rsp_type e;
         checked++;
         if (pending_rsp.size() == 0) begin
            report("unexpected result", 0, 0);
            return;
         end
         e = pending_rsp.pop_front();
         if (g.status !== e.status) report("status", g.status, e.status);
         if (g.enable_cmd !== e.enable_cmd) report("enable_cmd", g.enable_cmd, e.enable_cmd);
         if (g.rd_pos !== e.rd_pos)
            report("rd_pos", g.rd_pos, e.rd_pos);
         if (g.wr_pos !== e.wr_pos)
            report("wr_pos", g.wr_pos, e.wr_pos);
         if (g.busy_res !== e.busy_res) report("busy_res", g.busy_res, e.busy_res);
         if (g.pend_bytes !== e.pend_bytes)
            report("pend_bytes", g.pend_bytes, e.pend_bytes);
         if (g.free_space !== e.free_space) report("free_space", g.free_space, e.free_space);
         if (g.frame_format !== e.frame_format)
            report("frame_format", g.frame_format, e.frame_format);
      endtask
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   chan_scoreboard sb = new();
   int idle_cycles = 0;
   int n_sent = 0;
   int cfg_ok = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   ring_dma_channel_controller u_top (
      .clock(clock), .reset(reset), .start(start), .req_item(req_item),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         sb.note_request(req_item);
         if (req_item.req_type == REQ_CONFIGURE) cfg_ok++;
      end
      if (!reset && rsp_valid) sb.check_result(rsp_item);
   end

   // watchdog on cycles with no accepted item or result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("timeout waiting on the block");
         $display("== FAIL ==");
         $finish;
      end
   end

   // start stays high after acceptance until a gap or drain drops it
   task send_req(req_type r);
      req_item <= r;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task gap();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
      if (n != 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function req_type rand_fields();
      req_type r;
      r = '0;
      r.req_type = 3'($urandom_range(0, 7));
      r.chan_id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, NumChannels-1));
      r.transfer_dir = 2'($urandom);
      r.chan_is_playback = 1'($urandom);
      r.cyclic = 1'($urandom);
      r.blk_bytes = 24'($urandom);
      r.blk_cnt = 8'($urandom);
      r.src_addr = $urandom;
      r.dst_addr = $urandom;
      r.sample_bytes = 4'($urandom);
      r.advance_bytes = $urandom;
      r.hw_position = $urandom;
      return r;
   endfunction

   // well-formed request on an in-range channel, random but mostly legal
   function req_type shaped_req();
      req_type r;
      int k;
      r = rand_fields();
      r.chan_id = 8'($urandom_range(0, NumChannels-1));
      k = $urandom_range(0, 9);
      if (k < 2) begin
         r.req_type = REQ_CONFIGURE;
         r.cyclic = 1;
         r.chan_is_playback = 1'($urandom);
         r.transfer_dir = r.chan_is_playback ? 2'd0 : 2'd1;
         r.blk_bytes = ($urandom_range(0, 7) == 0) ? 24'hffffff : 24'($urandom_range(1, 4096));
         r.blk_cnt = ($urandom_range(0, 7) == 0) ? 8'hff : 8'($urandom_range(1, 8));
         r.sample_bytes = $urandom_range(0, 1) ? SampleS16 : SampleS32;
      end else if (k < 6) begin
         r.req_type = 3'($urandom_range(REQ_START, REQ_RESUME));
      end else if (k < 8) begin
         r.req_type = REQ_RELOAD;
         if ($urandom_range(0, 1)) r.advance_bytes = $urandom_range(0, 40000);
      end else begin
         r.req_type = REQ_STATUS;
         if ($urandom_range(0, 1)) r.hw_position = r.src_addr + $urandom_range(0, 40000);
      end
      return r;
   endfunction

   task drain();
      start <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   initial begin
      req_type r;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: bad channel, unknown code, configure checks, state moves, reload and status
      r = '0; r.req_type = REQ_START; r.chan_id = 8'hff; send_req(r);
      r = '0; r.req_type = REQ_UNKNOWN; send_req(r);
      r = '0; r.req_type = REQ_STOP; send_req(r);
      r = '0; r.req_type = REQ_RELOAD; r.advance_bytes = '1; send_req(r);
      r = '0; r.req_type = REQ_STATUS; r.hw_position = 32'h10; send_req(r);
      r = '0; r.req_type = REQ_CONFIGURE; r.cyclic = 0; send_req(r);
      r.cyclic = 1; r.blk_bytes = 0; r.blk_cnt = 1; send_req(r);
      r.blk_bytes = 24'hffffff; r.blk_cnt = 0; send_req(r);
      r.blk_cnt = 8'hff; r.transfer_dir = 2'd3; send_req(r);
      r.transfer_dir = 0; r.chan_is_playback = 0; send_req(r);
      r.transfer_dir = 1; r.chan_is_playback = 1; send_req(r);
      r.transfer_dir = 0; r.src_addr = '1; r.sample_bytes = 4'hf; send_req(r);
      r.sample_bytes = SampleS32; send_req(r);
      r.req_type = REQ_RESUME; send_req(r);
      r.req_type = REQ_START; send_req(r);
      r.req_type = REQ_SUSPEND; send_req(r);
      r.req_type = REQ_RESUME; send_req(r);
      r.req_type = REQ_RELOAD; r.advance_bytes = '1; send_req(r);
      r.req_type = REQ_STATUS; r.hw_position = 0; send_req(r);
      r.hw_position = '1; send_req(r);
      r.req_type = REQ_STOP; send_req(r);
      r = '0; r.req_type = REQ_CONFIGURE; r.chan_id = 8'(NumChannels - 1); r.cyclic = 1;
      r.transfer_dir = 1; r.blk_bytes = 24'd100; r.blk_cnt = 8'd3;
      r.dst_addr = 32'hffff_ff00; r.sample_bytes = SampleS16; send_req(r);
      r.req_type = REQ_STATUS; r.hw_position = 32'h0000_0500; send_req(r);
      r.req_type = REQ_RELOAD; r.advance_bytes = 32'd250; send_req(r);
      r.req_type = REQ_STATUS; send_req(r);
      drain();

      for (int i = 0; i < 1800; i++) begin
         if ($urandom_range(0, 4) == 0) r = rand_fields();
         else r = shaped_req();
         send_req(r);
         n_sent++;
         if (i == 900) drain();
         else gap();
      end
      drain();

      $display("ran %0d random requests, %0d configure requests, %0d results checked",
               n_sent, cfg_ok, sb.checked);
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
